// ----- rtl/pokd_pkg.sv -----
// Package: MD5 round constants, message layout helpers and shared types for the key deriver.
package pokd_pkg;

    localparam int ROUNDS = 64;
    localparam int STAGES = ROUNDS + 2;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;
    localparam logic [1:0] CFG_OBF      = 2'd3;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] OBF_X0 = 8'hac;
    localparam logic [7:0] OBF_X1 = 8'h96;
    localparam logic [7:0] OBF_X2 = 8'h69;
    localparam logic [7:0] OBF_X3 = 8'hca;
    localparam logic [7:0] OBF_X4 = 8'h35;
    localparam logic [31:0] SALT  = {8'h54, 8'h6c, 8'h41, 8'h73}; // "sAlT", 's' lowest

    localparam logic [4:0] KEY_MIN = 5'd5;
    localparam logic [4:0] KEY_MAX = 5'd16;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_state_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
            32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
            32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
            32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
            32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
            32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
            32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
            32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
            32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
            32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
            32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] md5_r(input logic [5:0] i);
        logic [4:0] r [16];
        r = '{5'd7,5'd12,5'd17,5'd22,5'd5,5'd9,5'd14,5'd20,
              5'd4,5'd11,5'd16,5'd23,5'd6,5'd10,5'd15,5'd21};
        return r[{i[5:4], i[1:0]}];
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            2'd3: g = 4'(7 * i[3:0]);
            default: g = i[3:0];
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (i[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/pdf_object_key_derive.sv -----
// Top level: pipelined per-object key derivation with one MD5 round per stage.
// One key per cycle unless stalled: one stage builds the 64-byte block, 64 stages each run
// one MD5 round (the round adder chain sets the clock), and one output register adds the chaining
// value and masks the key to its length. The whole pipeline advances when the output register is
// empty or being taken, so a stall holds every stage and a bubble travels as a cleared valid bit.
// Configuration is sampled when a transaction enters; write it only while the pipeline is empty.
// A key byte count below 5 acts as 5, above 16 as 16.
module pdf_object_key_derive (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // object_number[23:0], generation[39:24]
    input  logic         s_tuser,   // use_aes_salt
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // key_low[63:0], key_high[127:64], key_length[132:128]
);
    import pokd_pkg::*;

    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  count_reg;
    logic        obf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            count_reg    <= KEY_MIN;
            obf_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_COUNT:    count_reg    <= cfg_data[4:0];
                CFG_OBF:      obf_reg      <= cfg_data[0];
                default:      obf_reg      <= obf_reg;
            endcase
        end
    end

    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Clamp the key count and assemble the padded message block.
    // The tail holds the id bytes, the optional salt and the 0x80 pad byte.
    logic [4:0]   n;
    logic [127:0] fkey;
    logic [79:0]  tail;
    logic [6:0]   msg_len;
    logic         salt;
    logic [511:0] blk_next;
    logic [39:0]  id_bytes;

    always_comb
    begin
        if (count_reg < KEY_MIN)
            n = KEY_MIN;
        else if (count_reg > KEY_MAX)
            n = KEY_MAX;
        else
            n = count_reg;
        salt = s_tuser || obf_reg;
        if (obf_reg)
            id_bytes = {s_tdata[23:16] ^ OBF_X4, s_tdata[39:32] ^ OBF_X3,
                        s_tdata[15:8] ^ OBF_X2, s_tdata[31:24] ^ OBF_X1,
                        s_tdata[7:0] ^ OBF_X0};
        else
            id_bytes = s_tdata;
        tail = salt ? {8'h80, SALT, id_bytes[39:0]} : {32'h0, 8'h80, id_bytes};
        msg_len = 7'(n) + (salt ? 7'd9 : 7'd5);
        fkey = {key_high_reg, key_low_reg} & ~({128{1'b1}} << {n, 3'b000});
        blk_next = {512{1'b0}};
        blk_next[127:0] = fkey;
        blk_next = blk_next | ({432'h0, tail} << {n, 3'b000});
        blk_next[511:448] = {54'h0, msg_len, 3'b000};
    end

    // Pipeline: stage 0 holds the block, stage r+1 holds state after round r.
    logic [511:0] blk_reg   [ROUNDS+1];
    md5_state_t   st_reg    [ROUNDS+1];
    logic         vld_reg   [ROUNDS+1];
    logic [4:0]   len_reg   [ROUNDS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (advance)
            vld_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blk_reg[0] <= blk_next;
            st_reg[0]  <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            len_reg[0] <= (n + 5'd5 > KEY_MAX) ? KEY_MAX : n + 5'd5;
        end
    end

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        localparam logic [5:0] RI = 6'(r);
        logic [31:0] m_word, sum, rot;
        md5_state_t  cur, nxt;
        always_comb
        begin
            cur = st_reg[r];
            m_word = blk_reg[r][{md5_g(RI), 5'b00000} +: 32];
            sum = cur.a + md5_f(RI, cur.b, cur.c, cur.d) + md5_k(RI) + m_word;
            rot = (sum << md5_r(RI)) | (sum >> (6'd32 - {1'b0, md5_r(RI)}));
            nxt.a = cur.d;
            nxt.d = cur.c;
            nxt.c = cur.b;
            nxt.b = cur.b + rot;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[r+1] <= 1'b0;
            else if (advance)
                vld_reg[r+1] <= vld_reg[r];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[r+1]  <= nxt;
                blk_reg[r+1] <= blk_reg[r];
                len_reg[r+1] <= len_reg[r];
            end
        end
    end

    // Final chaining add and length mask.
    md5_state_t  fin;
    logic [127:0] digest;
    assign fin = st_reg[ROUNDS];
    assign digest = {fin.d + IV_D, fin.c + IV_C, fin.b + IV_B, fin.a + IV_A};

    logic [135:0] out_reg;
    logic         out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= vld_reg[ROUNDS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= {3'b000, len_reg[ROUNDS],
                        digest & ~({128{1'b1}} << {len_reg[ROUNDS], 3'b000})};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
endmodule
